// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/cau_pkg.sv -----
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef struct packed {
    logic vld;
    op_t  op;
    logic dz;
  } ctl_t;

endpackage
`default_nettype wire

// ----- sv/cau_front.sv -----
`default_nettype none
module cau_front #(
  parameter int DW   = 16,
  parameter int FRAC = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          vld_i,
  input  wire  [1:0]                   op_i,
  input  wire  signed [DW-1:0]         a_re,
  input  wire  signed [DW-1:0]         a_im,
  input  wire  signed [DW-1:0]         b_re,
  input  wire  signed [DW-1:0]         b_im,
  output cau_pkg::ctl_t                ctl_o,
  output logic signed [2*DW:0]         alt_re_o,
  output logic signed [2*DW:0]         alt_im_o,
  output logic [2*DW+FRAC:0]           mag_re_o,
  output logic [2*DW+FRAC:0]           mag_im_o,
  output logic                         neg_re_o,
  output logic                         neg_im_o,
  output logic [2*DW-1:0]              den_o
);
  localparam int PW   = 2 * DW;
  localparam int SUMW = 2 * DW + 1;
  localparam int NW   = SUMW + FRAC;

  cau_pkg::ctl_t ctl1_r, ctl1_nxt, ctl2_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, d_rr_r, d_ii_r;
  logic signed [DW:0]   s_re_r, s_im_r, s_re_nxt, s_im_nxt;
  logic signed [DW:0]   ar_x, ai_x, br_x, bi_x;

  logic signed [SUMW-1:0] m_re, m_im, n_re, n_im;
  logic [SUMW-1:0]        abs_re, abs_im;
  logic signed [SUMW-1:0] alt_re_nxt, alt_im_nxt;
  logic [NW-1:0]          mag_re_nxt, mag_im_nxt;
  logic [PW-1:0]          den_nxt;

  // stage 1: products and add/sub
  always_comb begin
    ar_x = (DW+1)'(a_re);
    ai_x = (DW+1)'(a_im);
    br_x = (DW+1)'(b_re);
    bi_x = (DW+1)'(b_im);
    if (cau_pkg::op_t'(op_i) == cau_pkg::OP_SUB) begin
      s_re_nxt = ar_x - br_x;
      s_im_nxt = ai_x - bi_x;
    end else begin
      s_re_nxt = ar_x + br_x;
      s_im_nxt = ai_x + bi_x;
    end
    ctl1_nxt.vld = vld_i;
    ctl1_nxt.op  = cau_pkg::op_t'(op_i);
    ctl1_nxt.dz  = (b_re == '0) && (b_im == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= a_re * b_re;
      p_ii_r <= a_im * b_im;
      p_ri_r <= a_re * b_im;
      p_ir_r <= a_im * b_re;
      d_rr_r <= b_re * b_re;
      d_ii_r <= b_im * b_im;
      s_re_r <= s_re_nxt;
      s_im_r <= s_im_nxt;
    end
  end

  // stage 2: sums, scaling, divider operands
  always_comb begin
    m_re   = (SUMW'(p_rr_r) - SUMW'(p_ii_r)) >>> FRAC;
    m_im   = (SUMW'(p_ri_r) + SUMW'(p_ir_r)) >>> FRAC;
    n_re   = SUMW'(p_rr_r) + SUMW'(p_ii_r);
    n_im   = SUMW'(p_ir_r) - SUMW'(p_ri_r);
    abs_re = n_re[SUMW-1] ? $unsigned(-n_re) : $unsigned(n_re);
    abs_im = n_im[SUMW-1] ? $unsigned(-n_im) : $unsigned(n_im);
    mag_re_nxt = NW'(abs_re) << FRAC;
    mag_im_nxt = NW'(abs_im) << FRAC;
    den_nxt    = $unsigned(d_rr_r) + $unsigned(d_ii_r);
    if (ctl1_r.op == cau_pkg::OP_ADD || ctl1_r.op == cau_pkg::OP_SUB) begin
      alt_re_nxt = SUMW'(s_re_r);
      alt_im_nxt = SUMW'(s_im_r);
    end else begin
      alt_re_nxt = m_re;
      alt_im_nxt = m_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alt_re_o <= alt_re_nxt;
      alt_im_o <= alt_im_nxt;
      mag_re_o <= mag_re_nxt;
      mag_im_o <= mag_im_nxt;
      neg_re_o <= n_re[SUMW-1];
      neg_im_o <= n_im[SUMW-1];
      den_o    <= den_nxt;
    end
  end

  assign ctl_o = ctl2_r;

endmodule
`default_nettype wire

// ----- sv/cau_div_stage.sv -----
`default_nettype none
module cau_div_stage #(
  parameter int DW   = 16,
  parameter int FRAC = 8,
  parameter int IDX  = 0
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire  cau_pkg::ctl_t    ctl_i,
  input  wire  signed [2*DW:0]   alt_re_i,
  input  wire  signed [2*DW:0]   alt_im_i,
  input  wire  [2*DW+FRAC:0]     rem_re_i,
  input  wire  [2*DW+FRAC:0]     rem_im_i,
  input  wire                    neg_re_i,
  input  wire                    neg_im_i,
  input  wire  [2*DW-1:0]        den_i,
  input  wire  [DW+1:0]          q_re_i,
  input  wire  [DW+1:0]          q_im_i,
  output cau_pkg::ctl_t          ctl_o,
  output logic signed [2*DW:0]   alt_re_o,
  output logic signed [2*DW:0]   alt_im_o,
  output logic [2*DW+FRAC:0]     rem_re_o,
  output logic [2*DW+FRAC:0]     rem_im_o,
  output logic                   neg_re_o,
  output logic                   neg_im_o,
  output logic [2*DW-1:0]        den_o,
  output logic [DW+1:0]          q_re_o,
  output logic [DW+1:0]          q_im_o
);
  localparam int NW  = 2 * DW + 1 + FRAC;
  localparam int QTW = DW + 2;
  localparam int CW  = NW + 2 * DW + QTW;

  cau_pkg::ctl_t ctl_r;
  logic [CW-1:0]  sh, r_re, r_im;
  logic           ge_re, ge_im;
  logic [NW-1:0]  rem_re_nxt, rem_im_nxt;
  logic [QTW-1:0] q_re_nxt, q_im_nxt;

  // one restoring step per part, shared divisor
  always_comb begin
    sh    = CW'(den_i) << IDX;
    r_re  = CW'(rem_re_i);
    r_im  = CW'(rem_im_i);
    ge_re = r_re >= sh;
    ge_im = r_im >= sh;
    rem_re_nxt = ge_re ? NW'(r_re - sh) : rem_re_i;
    rem_im_nxt = ge_im ? NW'(r_im - sh) : rem_im_i;
    q_re_nxt = q_re_i;
    q_im_nxt = q_im_i;
    q_re_nxt[IDX] = ge_re;
    q_im_nxt[IDX] = ge_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alt_re_o <= alt_re_i;
      alt_im_o <= alt_im_i;
      rem_re_o <= rem_re_nxt;
      rem_im_o <= rem_im_nxt;
      neg_re_o <= neg_re_i;
      neg_im_o <= neg_im_i;
      den_o    <= den_i;
      q_re_o   <= q_re_nxt;
      q_im_o   <= q_im_nxt;
    end
  end

  assign ctl_o = ctl_r;

endmodule
`default_nettype wire

// ----- sv/cau_back.sv -----
`default_nettype none
module cau_back #(
  parameter int DW = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire  cau_pkg::ctl_t    ctl_i,
  input  wire  signed [2*DW:0]   alt_re_i,
  input  wire  signed [2*DW:0]   alt_im_i,
  input  wire                    neg_re_i,
  input  wire                    neg_im_i,
  input  wire  [DW+1:0]          q_re_i,
  input  wire  [DW+1:0]          q_im_i,
  output logic                   vld_o,
  output logic signed [DW-1:0]   res_re_o,
  output logic signed [DW-1:0]   res_im_o,
  output logic [1:0]             status_o
);
  localparam int SUMW = 2 * DW + 1;
  localparam int QW   = DW + 1;
  localparam logic signed [SUMW-1:0] HI = {{(SUMW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] LO = {{(SUMW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic                  vld_r;
  logic signed [DW-1:0]  res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  cau_pkg::status_t      status_r, status_nxt;
  logic                  is_div;
  logic signed [SUMW-1:0] v_re, v_im;
  logic                  hi_re, lo_re, hi_im, lo_im;

  always_comb begin
    is_div = (ctl_i.op == cau_pkg::OP_DIV);
    v_re   = alt_re_i;
    v_im   = alt_im_i;
    if (is_div) begin
      v_re = neg_re_i ? -$signed(SUMW'(q_re_i[QW-1:0])) : $signed(SUMW'(q_re_i[QW-1:0]));
      v_im = neg_im_i ? -$signed(SUMW'(q_im_i[QW-1:0])) : $signed(SUMW'(q_im_i[QW-1:0]));
    end
    hi_re = v_re > HI;
    lo_re = v_re < LO;
    hi_im = v_im > HI;
    lo_im = v_im < LO;
    // quotient beyond the divider range
    if (is_div && q_re_i[QW]) begin
      hi_re = !neg_re_i;
      lo_re = neg_re_i;
    end
    if (is_div && q_im_i[QW]) begin
      hi_im = !neg_im_i;
      lo_im = neg_im_i;
    end
    res_re_nxt = hi_re ? DW'(HI) : (lo_re ? DW'(LO) : DW'(v_re));
    res_im_nxt = hi_im ? DW'(HI) : (lo_im ? DW'(LO) : DW'(v_im));
    if (is_div && ctl_i.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = cau_pkg::ST_DIVZERO;
    end else if (hi_re || lo_re || hi_im || lo_im) begin
      status_nxt = cau_pkg::ST_SAT;
    end else begin
      status_nxt = cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign vld_o    = vld_r;
  assign res_re_o = res_re_r;
  assign res_im_o = res_im_r;
  assign status_o = status_r;

endmodule
`default_nettype wire

// ----- sv/complex_arith_unit_core.sv -----
// complex arithmetic unit: add, subtract, multiply, divide on signed fixed point
// input channel: in_valid/in_stall with in_req_type, in_a_re, in_a_im, in_b_re, in_b_im
// result channel: out_valid/out_stall with out_res_re, out_res_im, out_status
// status: ok, divide by zero (result zero) or saturated (part clamped to range)
// throughput: one beat per cycle unless out_stall holds the pipeline; every op takes the same path so order is kept
// the depth is set by the restoring divider, one quotient bit per stage
// front end: two stages of products and sums, back end: one saturation stage
// all stages move together; the pipeline holds when a result waits under
// out_stall, and in_stall follows out_stall only while a result is waiting
// bubbles move up while the output register is empty
// reset (synchronous, rst_n low) clears every valid bit; data is not cleared
`default_nettype none
module complex_arith_unit_core #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   in_req_type,
  input  wire  signed [DATA_WIDTH-1:0] in_a_re,
  input  wire  signed [DATA_WIDTH-1:0] in_a_im,
  input  wire  signed [DATA_WIDTH-1:0] in_b_re,
  input  wire  signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);
  localparam int DW   = DATA_WIDTH;
  localparam int SUMW = 2 * DW + 1;
  localparam int NW   = SUMW + FRAC_BITS;
  localparam int DENW = 2 * DW;
  localparam int QTW  = DW + 2;
  localparam int NSTG = DW + 2;
  localparam logic signed [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};

  logic adv;
  logic res_zero, res_at_lim;

  cau_pkg::ctl_t          ctl_s   [NSTG+1];
  logic signed [SUMW-1:0] alt_re_s[NSTG+1];
  logic signed [SUMW-1:0] alt_im_s[NSTG+1];
  logic [NW-1:0]          rem_re_s[NSTG+1];
  logic [NW-1:0]          rem_im_s[NSTG+1];
  logic                   neg_re_s[NSTG+1];
  logic                   neg_im_s[NSTG+1];
  logic [DENW-1:0]        den_s   [NSTG+1];
  logic [QTW-1:0]         q_re_s  [NSTG+1];
  logic [QTW-1:0]         q_im_s  [NSTG+1];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  cau_front #(.DW(DW), .FRAC(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_i    (in_valid),
    .op_i     (in_req_type),
    .a_re     (in_a_re),
    .a_im     (in_a_im),
    .b_re     (in_b_re),
    .b_im     (in_b_im),
    .ctl_o    (ctl_s[0]),
    .alt_re_o (alt_re_s[0]),
    .alt_im_o (alt_im_s[0]),
    .mag_re_o (rem_re_s[0]),
    .mag_im_o (rem_im_s[0]),
    .neg_re_o (neg_re_s[0]),
    .neg_im_o (neg_im_s[0]),
    .den_o    (den_s[0])
  );

  assign q_re_s[0] = '0;
  assign q_im_s[0] = '0;

  for (genvar j = 0; j < NSTG; j++) begin : g_div
    cau_div_stage #(.DW(DW), .FRAC(FRAC_BITS), .IDX(NSTG - 1 - j)) u_stg (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .ctl_i    (ctl_s[j]),
      .alt_re_i (alt_re_s[j]),
      .alt_im_i (alt_im_s[j]),
      .rem_re_i (rem_re_s[j]),
      .rem_im_i (rem_im_s[j]),
      .neg_re_i (neg_re_s[j]),
      .neg_im_i (neg_im_s[j]),
      .den_i    (den_s[j]),
      .q_re_i   (q_re_s[j]),
      .q_im_i   (q_im_s[j]),
      .ctl_o    (ctl_s[j+1]),
      .alt_re_o (alt_re_s[j+1]),
      .alt_im_o (alt_im_s[j+1]),
      .rem_re_o (rem_re_s[j+1]),
      .rem_im_o (rem_im_s[j+1]),
      .neg_re_o (neg_re_s[j+1]),
      .neg_im_o (neg_im_s[j+1]),
      .den_o    (den_s[j+1]),
      .q_re_o   (q_re_s[j+1]),
      .q_im_o   (q_im_s[j+1])
    );
  end

  cau_back #(.DW(DW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .ctl_i    (ctl_s[NSTG]),
    .alt_re_i (alt_re_s[NSTG]),
    .alt_im_i (alt_im_s[NSTG]),
    .neg_re_i (neg_re_s[NSTG]),
    .neg_im_i (neg_im_s[NSTG]),
    .q_re_i   (q_re_s[NSTG]),
    .q_im_i   (q_im_s[NSTG]),
    .vld_o    (out_valid),
    .res_re_o (out_res_re),
    .res_im_o (out_res_im),
    .status_o (out_status)
  );

  assign res_zero   = (out_res_re == '0) && (out_res_im == '0);
  assign res_at_lim = (out_res_re == RES_MAX) || (out_res_re == RES_MIN) ||
                      (out_res_im == RES_MAX) || (out_res_im == RES_MIN);

`include "assert_macros.svh"

  `CAU_ASSERT_IMP(a_stall_only_on_wait, clk, rst_n, in_stall, out_valid && out_stall)
  `CAU_ASSERT_IMP(a_divzero_gives_zero, clk, rst_n, out_valid && (out_status == cau_pkg::ST_DIVZERO), res_zero)
  `CAU_ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_valid && (out_status == cau_pkg::ST_SAT), res_at_lim)
  `CAU_ASSERT_NXT(a_hold_in_stall, clk, rst_n, out_valid && out_stall, out_valid)

endmodule
`default_nettype wire

// ----- verif/tb_complex_arith_unit_core.sv -----
`default_nettype none
module tb_complex_arith_unit_core;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int LATENCY = DW + 5;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    cau_pkg::op_t op;
    logic signed [DW-1:0] a_re, a_im, b_re, b_im;
  } cplx_req_t;

  typedef struct {
    logic signed [DW-1:0] re, im;
    cau_pkg::status_t st;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic signed [DW-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic [1:0] out_status;

  cplx_req_t pending_reqs[$];
  cplx_res_t expected_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit stim_done = 1'b0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  complex_arith_unit_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_re(out_res_re), .out_res_im(out_res_im), .out_status(out_status)
  );

  function automatic longint clamp_part(longint x, ref bit sat);
    longint hi, lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (x < lo) begin
      sat = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic cplx_res_t compute_complex(cplx_req_t r);
    cplx_res_t res;
    longint ar, ai, br, bi, rr, ri, den;
    bit sat;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    rr = 0; ri = 0; sat = 1'b0;
    res.st = cau_pkg::ST_OK;
    case (r.op)
      cau_pkg::OP_ADD: begin
        rr = ar + br;
        ri = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        rr = ar - br;
        ri = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        rr = (ar * br - ai * bi) >>> FB;
        ri = (ar * bi + ai * br) >>> FB;
      end
      default: begin
        if (br == 0 && bi == 0) begin
          res.st = cau_pkg::ST_DIVZERO;
        end else begin
          den = br * br + bi * bi;
          rr = ((ar * br + ai * bi) <<< FB) / den;
          ri = ((ai * br - ar * bi) <<< FB) / den;
        end
      end
    endcase
    if (res.st == cau_pkg::ST_OK) begin
      rr = clamp_part(rr, sat);
      ri = clamp_part(ri, sat);
      if (sat) res.st = cau_pkg::ST_SAT;
    end
    res.re = rr[DW-1:0];
    res.im = ri[DW-1:0];
    return res;
  endfunction

  function automatic logic signed [DW-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return DW'($signed($urandom_range(0, 1023)) - 512);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic push_req(cau_pkg::op_t op, logic signed [DW-1:0] ar, ai, br, bi);
    cplx_req_t r;
    r.op = op; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
    pending_reqs.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    cplx_req_t r;
    if (rst_n && !(in_valid && in_stall)) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req_type <= r.op;
        in_a_re <= r.a_re; in_a_im <= r.a_im;
        in_b_re <= r.b_re; in_b_im <= r.b_im;
        expected_results.push_back(compute_complex(r));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cplx_res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_res_re !== e.re) begin
            $error("res_re exp %0d got %0d", e.re, out_res_re);
            errors++;
          end
          if (out_res_im !== e.im) begin
            $error("res_im exp %0d got %0d", e.im, out_res_im);
            errors++;
          end
          if (out_status !== e.st) begin
            $error("status exp %0d got %0d", e.st, out_status);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[complex_arith_unit_core] ERROR");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed beats
    for (int o = 0; o < 4; o++) begin
      push_req(cau_pkg::op_t'(o), 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      push_req(cau_pkg::op_t'(o), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      push_req(cau_pkg::op_t'(o), 16'sh0100, 16'shff00, 16'sh0200, 16'sh0080);
      push_req(cau_pkg::op_t'(o), 16'sh1234, 16'shedcb, 16'sh0000, 16'sh0000);
    end
    push_req(cau_pkg::OP_SUB, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000);
    push_req(cau_pkg::OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000);
    push_req(cau_pkg::OP_DIV, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0001);
    push_req(cau_pkg::OP_MUL, 16'shffff, 16'sh0001, 16'sh0001, 16'sh0001);
    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending_reqs.size() == 0);
      idle_pct = (ph == 1) ? 62 : (ph == 3) ? 27 : 0;
      stall_pct = (ph == 2) ? 62 : (ph == 3) ? 27 : 0;
      for (k = 0; k < 200; k++)
        push_req(cau_pkg::op_t'($urandom_range(0, 3)), rand_part(), rand_part(),
                 rand_part(), rand_part());
    end
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("[complex_arith_unit_core] OK");
    end else begin
      $display("[complex_arith_unit_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
